>>> hdl/tccw_pkg.sv
// ============================================================================
// tccw_pkg
// Shared types and constants for the text console character writer:
// item kinds, control characters, datapath command and status groups.
// ============================================================================
package tccw_pkg;

  localparam logic [1:0] KIND_PUT   = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [7:0]  ATTR_RESET = 8'h70;
  localparam logic [15:0] CELL_RESET = {ATTR_RESET, CH_SPACE};

  // write data select
  localparam logic [1:0] WS_CHAR   = 2'd0;
  localparam logic [1:0] WS_BLANK  = 2'd1;
  localparam logic [1:0] WS_INIT   = 2'd2;
  localparam logic [1:0] WS_SCROLL = 2'd3;

  // write address select
  localparam logic [1:0] WA_CUR    = 2'd0;
  localparam logic [1:0] WA_CUR_M1 = 2'd1;
  localparam logic [1:0] WA_SWEEP  = 2'd2;

  // cursor column ops
  localparam logic [1:0] COL_HOLD = 2'd0;
  localparam logic [1:0] COL_INC  = 2'd1;
  localparam logic [1:0] COL_DEC  = 2'd2;
  localparam logic [1:0] COL_ZERO = 2'd3;

  // cursor line ops
  localparam logic [1:0] LINE_HOLD = 2'd0;
  localparam logic [1:0] LINE_INC  = 2'd1;
  localparam logic [1:0] LINE_ZERO = 2'd2;

  // sweep read ops
  localparam logic [1:0] RD_NONE  = 2'd0;
  localparam logic [1:0] RD_SCRL0 = 2'd1;
  localparam logic [1:0] RD_SCRL  = 2'd2;

  typedef struct packed {
    logic       cap_item;
    logic       wr_en;
    logic [1:0] wsel;
    logic [1:0] wa_sel;
    logic [1:0] col_op;
    logic [1:0] line_op;
    logic [1:0] rd_op;
    logic       tab_step;
    logic       sw_clr;
    logic       sw_step;
    logic       load_out;
  } tccw_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       is_bs;
    logic       is_lf;
    logic       is_cr;
    logic       is_tab;
    logic       col_zero;
    logic       col_last;
    logic       line_last;
    logic       tab_last;
    logic       tab_more;
    logic       sw_last;
    logic       out_free;
  } tccw_sts_t;

endpackage

>>> hdl/tccw_ctrl.sv
// ============================================================================
// tccw_ctrl
// Controller: sequences each transaction through execute, scroll, clear and
// the clearing pass after reset, and hands the result to the output register.
// ============================================================================
module tccw_ctrl
  import tccw_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  tccw_sts_t sts,
  output tccw_cmd_t cmd
);

  localparam logic [2:0] ST_INIT  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_EXEC  = 3'd2;
  localparam logic [2:0] ST_SCRL0 = 3'd3;
  localparam logic [2:0] ST_SCRL  = 3'd4;
  localparam logic [2:0] ST_CLR   = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       finish;
  logic       more;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    finish    = 1'b0;
    more      = sts.is_tab && !sts.tab_last;
    case (state_r)
      ST_INIT: begin
        cmd.wr_en   = 1'b1;
        cmd.wsel    = WS_INIT;
        cmd.wa_sel  = WA_SWEEP;
        cmd.sw_step = 1'b1;
        if (sts.sw_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.cap_item = 1'b1;
          state_nxt    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (sts.kind)
          KIND_PUT: begin
            if (sts.is_bs) begin
              if (!sts.col_zero) begin
                cmd.wr_en  = 1'b1;
                cmd.wsel   = WS_BLANK;
                cmd.wa_sel = WA_CUR_M1;
                cmd.col_op = COL_DEC;
              end
              finish = 1'b1;
            end else if (sts.is_lf) begin
              cmd.col_op = COL_ZERO;
              if (sts.line_last) begin
                cmd.sw_clr = 1'b1;
                state_nxt  = ST_SCRL0;
              end else begin
                cmd.line_op = LINE_INC;
                finish      = 1'b1;
              end
            end else if (sts.is_cr) begin
              finish = 1'b1;
            end else begin
              cmd.wr_en    = 1'b1;
              cmd.wsel     = WS_CHAR;
              cmd.wa_sel   = WA_CUR;
              cmd.tab_step = sts.is_tab;
              if (sts.col_last) begin
                cmd.col_op = COL_ZERO;
                if (sts.line_last) begin
                  cmd.sw_clr = 1'b1;
                  state_nxt  = ST_SCRL0;
                end else begin
                  cmd.line_op = LINE_INC;
                  finish      = !more;
                end
              end else begin
                cmd.col_op = COL_INC;
                finish     = !more;
              end
            end
          end
          KIND_CLEAR: begin
            cmd.col_op  = COL_ZERO;
            cmd.line_op = LINE_ZERO;
            cmd.sw_clr  = 1'b1;
            state_nxt   = ST_CLR;
          end
          default: finish = 1'b1;
        endcase
        if (finish) begin
          if (sts.out_free) begin
            cmd.load_out = 1'b1;
            state_nxt    = ST_IDLE;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_SCRL0: begin
        cmd.rd_op = RD_SCRL0;
        state_nxt = ST_SCRL;
      end
      ST_SCRL: begin
        cmd.wr_en   = 1'b1;
        cmd.wsel    = WS_SCROLL;
        cmd.wa_sel  = WA_SWEEP;
        cmd.rd_op   = RD_SCRL;
        cmd.sw_step = 1'b1;
        if (sts.sw_last) state_nxt = sts.tab_more ? ST_EXEC : ST_FIN;
      end
      ST_CLR: begin
        cmd.wr_en   = 1'b1;
        cmd.wsel    = WS_BLANK;
        cmd.wa_sel  = WA_SWEEP;
        cmd.sw_step = 1'b1;
        if (sts.sw_last) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_INIT;
    else        state_r <= state_nxt;
  end

endmodule

>>> hdl/tccw_datapath.sv
// ============================================================================
// tccw_datapath
// Datapath: screen memory, cursor, sweep pointer, attribute register,
// captured transaction and output register.
// ============================================================================
module tccw_datapath
  import tccw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  input  tccw_cmd_t   cmd,
  output tccw_sts_t   sts,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_char_code,
  input  logic [4:0]  in_read_row,
  input  logic [6:0]  in_read_column,
  input  logic        cfg_valid,
  input  logic [7:0]  cfg_text_attribute,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [15:0] out_cell_value,
  output logic [6:0]  out_cursor_column,
  output logic [4:0]  out_cursor_row
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);

  logic [15:0]   mem [CELLS];
  logic [15:0]   rdata_r;
  logic [7:0]    attr_r;
  logic [1:0]    kind_r;
  logic [7:0]    char_r;
  logic          rd_ok_r;
  logic [1:0]    tab_cnt_r;
  logic [CW-1:0] col_r;
  logic [CW-1:0] col_nxt;
  logic [RW-1:0] line_r;
  logic [RW-1:0] line_nxt;
  logic [AW-1:0] sw_r;
  logic          out_valid_r;
  logic [15:0]   cell_r;
  logic [6:0]    ocol_r;
  logic [4:0]    orow_r;

  logic          item_ok;
  logic [AW-1:0] item_addr;
  logic [AW-1:0] cur_addr;
  logic [AW-1:0] waddr;
  logic [15:0]   wdata;
  logic [7:0]    wchar;
  logic          rd_en;
  logic [AW-1:0] raddr;
  int            sc_src;

  assign item_ok   = (int'(in_read_row) < ROWS) && (int'(in_read_column) < COLUMNS);
  assign item_addr = AW'(int'(in_read_row) * COLUMNS + int'(in_read_column));
  assign cur_addr  = AW'(int'(line_r) * COLUMNS + int'(col_r));
  assign wchar     = (char_r == CH_TAB) ? CH_SPACE : char_r;

  always_comb begin
    case (cmd.wa_sel)
      WA_CUR_M1: waddr = cur_addr - AW'(1);
      WA_SWEEP:  waddr = sw_r;
      default:   waddr = cur_addr;
    endcase
    case (cmd.wsel)
      WS_BLANK:  wdata = {attr_r, CH_SPACE};
      WS_INIT:   wdata = CELL_RESET;
      WS_SCROLL: wdata = (int'(sw_r) < CELLS - COLUMNS) ? rdata_r : {attr_r, CH_SPACE};
      default:   wdata = {attr_r, wchar};
    endcase
  end

  always_comb begin
    sc_src = int'(sw_r) + COLUMNS + ((cmd.rd_op == RD_SCRL) ? 1 : 0);
    rd_en  = 1'b0;
    raddr  = item_addr;
    case (cmd.rd_op)
      RD_SCRL0, RD_SCRL: begin
        rd_en = (sc_src < CELLS);
        raddr = AW'(sc_src);
      end
      default: rd_en = cmd.cap_item && (in_kind == KIND_READ) && item_ok;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[waddr] <= wdata;
    if (rd_en)     rdata_r    <= mem[raddr];
  end

  always_comb begin
    case (cmd.col_op)
      COL_INC:  col_nxt = col_r + CW'(1);
      COL_DEC:  col_nxt = col_r - CW'(1);
      COL_ZERO: col_nxt = '0;
      default:  col_nxt = col_r;
    endcase
    case (cmd.line_op)
      LINE_INC:  line_nxt = line_r + RW'(1);
      LINE_ZERO: line_nxt = '0;
      default:   line_nxt = line_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r      <= ATTR_RESET;
      col_r       <= '0;
      line_r      <= '0;
      sw_r        <= '0;
      tab_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) attr_r <= cfg_text_attribute;
      col_r  <= col_nxt;
      line_r <= line_nxt;
      if (cmd.sw_clr)       sw_r <= '0;
      else if (cmd.sw_step) sw_r <= (sw_r == AW'(CELLS - 1)) ? '0 : sw_r + AW'(1);
      if (cmd.cap_item)      tab_cnt_r <= '0;
      else if (cmd.tab_step) tab_cnt_r <= tab_cnt_r + 2'd1;
      if (cmd.load_out)      out_valid_r <= 1'b1;
      else if (!out_stall)   out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_item) begin
      kind_r  <= in_kind;
      char_r  <= in_char_code;
      rd_ok_r <= item_ok;
    end
    if (cmd.load_out) begin
      cell_r <= (kind_r == KIND_READ && rd_ok_r) ? rdata_r : 16'h0000;
      ocol_r <= 7'(col_nxt);
      orow_r <= 5'(line_nxt);
    end
  end

  always_comb begin
    sts.kind      = kind_r;
    sts.is_bs     = (char_r == CH_BS);
    sts.is_lf     = (char_r == CH_LF);
    sts.is_cr     = (char_r == CH_CR);
    sts.is_tab    = (char_r == CH_TAB);
    sts.col_zero  = (col_r == '0);
    sts.col_last  = (int'(col_r) == COLUMNS - 1);
    sts.line_last = (int'(line_r) >= ROWS - 1);
    sts.tab_last  = (tab_cnt_r == 2'd3);
    sts.tab_more  = (char_r == CH_TAB) && (kind_r == KIND_PUT) && (tab_cnt_r != 2'd0);
    sts.sw_last   = (sw_r == AW'(CELLS - 1));
    sts.out_free  = !out_valid_r || !out_stall;
  end

  assign out_valid         = out_valid_r;
  assign out_cell_value    = cell_r;
  assign out_cursor_column = ocol_r;
  assign out_cursor_row    = orow_r;

endmodule

>>> hdl/text_console_character_writer.sv
// ============================================================================
// text_console_character_writer
// Text-mode screen buffer with cursor: put character, read cell, clear screen.
// ============================================================================
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  in_      | in_valid / in_stall  | kind, char_code, read_row, read_column
//  out_     | out_valid / out_stall| cell_value, cursor_column, cursor_row
//  cfg_     | cfg_valid / cfg_ready| text_attribute
//
//  A tab writes four spaces. A scroll and a clear each sweep the whole
//  screen memory through its single write port.
//  After reset a clearing pass over every cell holds in_stall high.
//  One transaction at a time; a result waits in the output register under
//  out_stall.
module text_console_character_writer
  import tccw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_char_code,
  input  logic [4:0]  in_read_row,
  input  logic [6:0]  in_read_column,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_cell_value,
  output logic [6:0]  out_cursor_column,
  output logic [4:0]  out_cursor_row,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_text_attribute
);

  tccw_cmd_t cmd;
  tccw_sts_t sts;

  assign cfg_ready = 1'b1;

  tccw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tccw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_kind            (in_kind),
    .in_char_code       (in_char_code),
    .in_read_row        (in_read_row),
    .in_read_column     (in_read_column),
    .cfg_valid          (cfg_valid),
    .cfg_text_attribute (cfg_text_attribute),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_cell_value     (out_cell_value),
    .out_cursor_column  (out_cursor_column),
    .out_cursor_row     (out_cursor_row)
  );

endmodule

>>> hdl/tccw_checker.sv
// ============================================================================
// tccw_checker
// Port-level checks for the text console character writer, bound to the
// top level.
// ============================================================================
module tccw_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_cell_value,
  input logic [6:0]  out_cursor_column,
  input logic [4:0]  out_cursor_row
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_cell_value) && $stable(out_cursor_column)
                               && $stable(out_cursor_row))
    else $error("stalled result changed");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction taken while one is in progress");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_cursor_column) < COLUMNS) && (int'(out_cursor_row) < ROWS))
    else $error("cursor outside the screen");

endmodule

bind text_console_character_writer tccw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tccw_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_cell_value    (out_cell_value),
  .out_cursor_column (out_cursor_column),
  .out_cursor_row    (out_cursor_row)
);

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking bench for the text console character writer. A directed
// table covers reset contents, out-of-range reads, control characters and
// clear. Random traffic follows over several attribute settings, with
// scroll reached. Every result transaction is checked field by field
// against a behavioral screen and cursor predictor, or against the table
// entry where a directed row gives one. Both channels are throttled at random.
// ============================================================================
module tb_top
  import tccw_pkg::*;
();

  localparam int COLS  = 80;
  localparam int ROWS  = 25;
  localparam int CELLS = COLS * ROWS;
  localparam int DIR_N = 21;
  localparam int PHASE_ITEMS = 106;
  localparam logic [1:0] KIND_NONE = 2'd3;

  typedef struct packed {
    logic [15:0] cell_word;
    logic [6:0]  col;
    logic [4:0]  row;
  } console_result_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [7:0]      ch;
    logic [4:0]      row;
    logic [6:0]      col;
    logic            typed;
    console_result_t res;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_kind;
  logic [7:0]  in_char_code;
  logic [4:0]  in_read_row;
  logic [6:0]  in_read_column;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_cell_value;
  logic [6:0]  out_cursor_column;
  logic [4:0]  out_cursor_row;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_text_attribute;

  text_console_character_writer #(
    .COLUMNS(COLS),
    .ROWS   (ROWS)
  ) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_char_code      (in_char_code),
    .in_read_row       (in_read_row),
    .in_read_column    (in_read_column),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_cell_value    (out_cell_value),
    .out_cursor_column (out_cursor_column),
    .out_cursor_row    (out_cursor_row),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_text_attribute(cfg_text_attribute)
  );

  // screen and cursor predictor state
  logic [15:0]     screen_model [0:CELLS-1];
  int unsigned     cur_col;
  int unsigned     cur_line;
  logic [7:0]      attr_model;

  console_result_t cell_expect_q [$];
  stim_row_t       dir_tab [0:DIR_N-1];
  int              error_count;
  int              results_seen;
  bit              idle_on;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH @%0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  function automatic logic [15:0] blank_word();
    return {attr_model, CH_SPACE};
  endfunction

  task automatic scroll_model();
    logic [15:0] b;
    b = blank_word();
    for (int i = 0; i + COLS < CELLS; i++) screen_model[i] = screen_model[i + COLS];
    for (int i = CELLS - COLS; i < CELLS; i++) screen_model[i] = b;
  endtask

  task automatic clear_model();
    logic [15:0] b;
    b = blank_word();
    for (int i = 0; i < CELLS; i++) screen_model[i] = b;
    cur_col  = 0;
    cur_line = 0;
  endtask

  task automatic advance_line();
    if (cur_line >= ROWS - 1) scroll_model();
    else cur_line++;
    cur_col = 0;
  endtask

  task automatic write_glyph(input logic [7:0] ch);
    screen_model[cur_line * COLS + cur_col] = {attr_model, ch};
    cur_col++;
    if (cur_col >= COLS) advance_line();
  endtask

  task automatic console_predict(input logic [1:0] k, input logic [7:0] ch,
                                 input logic [4:0] r, input logic [6:0] c,
                                 output console_result_t res);
    res = '0;
    case (k)
      KIND_PUT: begin
        case (ch)
          CH_BS: begin
            if (cur_col > 0) begin
              cur_col--;
              screen_model[cur_line * COLS + cur_col] = blank_word();
            end
          end
          CH_LF:  advance_line();
          CH_CR:  ;
          CH_TAB: repeat (4) write_glyph(CH_SPACE);
          default: write_glyph(ch);
        endcase
      end
      KIND_READ: begin
        if (r < ROWS && c < COLS) res.cell_word = screen_model[r * COLS + c];
      end
      KIND_CLEAR: clear_model();
      default: ;
    endcase
    res.col = cur_col[6:0];
    res.row = cur_line[4:0];
  endtask

  task automatic offer_item(input logic [1:0] k, input logic [7:0] ch,
                            input logic [4:0] r, input logic [6:0] c,
                            input logic typed, input console_result_t typed_res,
                            input bit pause_after);
    console_result_t res;
    console_predict(k, ch, r, c, res);
    if (typed) res = typed_res;
    cell_expect_q.push_back(res);
    in_valid       <= 1'b1;
    in_kind        <= k;
    in_char_code   <= ch;
    in_read_row    <= r;
    in_read_column <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (pause_after || (idle_on && $urandom_range(0, 99) < 25)) begin
      in_valid <= 1'b0;
      if (!pause_after) repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic write_attribute(input logic [7:0] a);
    cfg_valid          <= 1'b1;
    cfg_text_attribute <= a;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid  <= 1'b0;
    attr_model = a;
  endtask

  task automatic check_result();
    console_result_t want;
    if (cell_expect_q.size() == 0) begin
      report_mismatch("unexpected result transaction", out_cell_value, 0);
    end else begin
      want = cell_expect_q.pop_front();
      if (out_cell_value !== want.cell_word)
        report_mismatch("cell_value", out_cell_value, want.cell_word);
      if (out_cursor_column !== want.col)
        report_mismatch("cursor_column", out_cursor_column, want.col);
      if (out_cursor_row !== want.row)
        report_mismatch("cursor_row", out_cursor_row, want.row);
    end
  endtask

  // result side: check, then throttle
  initial begin
    int  stall_left;
    bit  long_hold_done;
    stall_left     = 0;
    long_hold_done = 0;
    out_stall      <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        check_result();
        results_seen++;
      end
      if (results_seen == 150 && !long_hold_done) begin
        long_hold_done = 1;
        stall_left     = 400;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 99) < 6) begin
        stall_left = $urandom_range(1, 16) - 1;
        out_stall  <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // stimulus
  initial begin
    int          pick;
    logic [1:0]  k;
    logic [7:0]  ch;
    logic [4:0]  r;
    logic [6:0]  c;
    logic [7:0]  a;

    error_count  = 0;
    results_seen = 0;
    idle_on      = 1;
    attr_model   = ATTR_RESET;
    clear_model();

    rst_n              <= 1'b0;
    in_valid           <= 1'b0;
    in_kind            <= KIND_PUT;
    in_char_code       <= 8'h00;
    in_read_row        <= 5'd0;
    in_read_column     <= 7'd0;
    cfg_valid          <= 1'b0;
    cfg_text_attribute <= 8'h00;

    dir_tab[0]  = '{KIND_READ,  8'h00,    5'd0,  7'd0,   1'b1, '{CELL_RESET, 7'd0, 5'd0}};
    dir_tab[1]  = '{KIND_READ,  8'h00,    5'd24, 7'd79,  1'b1, '{CELL_RESET, 7'd0, 5'd0}};
    dir_tab[2]  = '{KIND_READ,  8'h00,    5'd25, 7'd0,   1'b1, '{16'h0000, 7'd0, 5'd0}};
    dir_tab[3]  = '{KIND_READ,  8'h00,    5'd0,  7'd80,  1'b1, '{16'h0000, 7'd0, 5'd0}};
    dir_tab[4]  = '{KIND_READ,  8'hFF,    5'd31, 7'd127, 1'b1, '{16'h0000, 7'd0, 5'd0}};
    dir_tab[5]  = '{KIND_NONE,  8'hFF,    5'd31, 7'd127, 1'b1, '{16'h0000, 7'd0, 5'd0}};
    dir_tab[6]  = '{KIND_PUT,   CH_BS,    5'd0,  7'd0,   1'b1, '{16'h0000, 7'd0, 5'd0}};
    dir_tab[7]  = '{KIND_PUT,   8'h41,    5'd0,  7'd0,   1'b0, '0};
    dir_tab[8]  = '{KIND_PUT,   8'hFF,    5'd0,  7'd0,   1'b0, '0};
    dir_tab[9]  = '{KIND_PUT,   8'h80,    5'd0,  7'd0,   1'b0, '0};
    dir_tab[10] = '{KIND_PUT,   CH_CR,    5'd0,  7'd0,   1'b0, '0};
    dir_tab[11] = '{KIND_PUT,   CH_TAB,   5'd0,  7'd0,   1'b0, '0};
    dir_tab[12] = '{KIND_PUT,   CH_BS,    5'd0,  7'd0,   1'b0, '0};
    dir_tab[13] = '{KIND_READ,  8'h00,    5'd0,  7'd0,   1'b0, '0};
    dir_tab[14] = '{KIND_READ,  8'h00,    5'd0,  7'd1,   1'b0, '0};
    dir_tab[15] = '{KIND_READ,  8'h00,    5'd0,  7'd5,   1'b0, '0};
    dir_tab[16] = '{KIND_PUT,   CH_LF,    5'd0,  7'd0,   1'b0, '0};
    dir_tab[17] = '{KIND_PUT,   8'h00,    5'd0,  7'd0,   1'b0, '0};
    dir_tab[18] = '{KIND_READ,  8'h00,    5'd1,  7'd0,   1'b0, '0};
    dir_tab[19] = '{KIND_CLEAR, 8'h00,    5'd0,  7'd0,   1'b1, '{16'h0000, 7'd0, 5'd0}};
    dir_tab[20] = '{KIND_READ,  8'h00,    5'd0,  7'd1,   1'b1, '{CELL_RESET, 7'd0, 5'd0}};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_N; i++)
      offer_item(dir_tab[i].kind, dir_tab[i].ch, dir_tab[i].row, dir_tab[i].col,
                 dir_tab[i].typed, dir_tab[i].res, i == DIR_N - 1);

    for (int ph = 1; ph <= 5; ph++) begin
      while (cell_expect_q.size() != 0) @(posedge clk);
      if (ph == 1) a = 8'hFF;
      else if (ph == 2) a = 8'h00;
      else a = 8'($urandom_range(0, 255));
      write_attribute(a);
      idle_on = (ph < 5);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 199);
        if (pick < 1) k = KIND_CLEAR;
        else if (pick < 7) k = KIND_NONE;
        else if (pick < 57) k = KIND_READ;
        else k = KIND_PUT;
        pick = $urandom_range(0, 99);
        if (pick < 18) ch = CH_LF;
        else if (pick < 24) ch = CH_BS;
        else if (pick < 28) ch = CH_TAB;
        else if (pick < 31) ch = CH_CR;
        else ch = 8'($urandom_range(0, 255));
        if (k == KIND_READ && $urandom_range(0, 7) != 0) begin
          r = 5'($urandom_range(0, ROWS - 1));
          c = 7'($urandom_range(0, COLS - 1));
        end else begin
          r = 5'($urandom_range(0, 31));
          c = 7'($urandom_range(0, 127));
        end
        offer_item(k, ch, r, c, 1'b0, '0, n == PHASE_ITEMS - 1);
      end
    end

    while (cell_expect_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (error_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> filelist.f
hdl/tccw_pkg.sv
hdl/tccw_ctrl.sv
hdl/tccw_datapath.sv
hdl/text_console_character_writer.sv
hdl/tccw_checker.sv
tb/tb_top.sv
